// ===== rtl/shpr_pkg.sv =====
// Shared types, constants and name tables for the sensor-hub packet receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package shpr_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W   = $clog2(CHANNELS + 1);

  localparam int POS_W    = 15;

  localparam logic [7:0] TAG_CHANNEL = 8'd6;
  localparam logic [7:0] TAG_NAME    = 8'd9;
  localparam logic [7:0] ROT_REPORT  = 8'd5;
  localparam logic [7:0] KIND_ADVERT = 8'd0;
  localparam logic [7:0] KIND_ERRORS = 8'd1;

  localparam logic [POS_W-1:0] REC_FIRST = POS_W'(5);
  localparam logic [POS_W-1:0] REC_NONE  = POS_W'(32767);

  typedef enum logic [3:0] {
    RES_EMPTY      = 4'd0,
    RES_SHORT      = 4'd1,
    RES_BAD_CH     = 4'd2,
    RES_ADVERT     = 4'd3,
    RES_ERROR_LIST = 4'd4,
    RES_RESERVED   = 4'd5,
    RES_CONTROL    = 4'd6,
    RES_ROTATION   = 4'd7,
    RES_SENSOR     = 4'd8,
    RES_UNASSIGNED = 4'd9
  } shpr_kind_t;

  typedef struct packed {
    logic [3:0]   pad;
    logic [15:0]  accuracy_est;
    logic [15:0]  quat_k;
    logic [15:0]  quat_j;
    logic [15:0]  quat_i;
    logic [15:0]  quat_real;
    logic [7:0]   report_status;
    logic [7:0]   seq_number;
    logic [7:0]   report_id;
    logic [7:0]   pkt_channel;
    shpr_kind_t   result_kind;
  } shpr_result_t;

  typedef struct packed {
    logic             restart;
    logic             take;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] len;
    logic [7:0]       data;
  } shpr_adv_req_t;

  typedef struct packed {
    logic [CHANNELS-1:0] valid_map;
    logic [7:0]          ctl_ch;
    logic [7:0]          inp_ch;
  } shpr_roles_t;

  function automatic logic [7:0] ctl_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h63;
      3'd1:    c = 8'h6F;
      3'd2:    c = 8'h6E;
      3'd3:    c = 8'h74;
      3'd4:    c = 8'h72;
      3'd5:    c = 8'h6F;
      3'd6:    c = 8'h6C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] inp_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h69;
      4'd1:    c = 8'h6E;
      4'd2:    c = 8'h70;
      4'd3:    c = 8'h75;
      4'd4:    c = 8'h74;
      4'd5:    c = 8'h4E;
      4'd6:    c = 8'h6F;
      4'd7:    c = 8'h72;
      4'd8:    c = 8'h6D;
      4'd9:    c = 8'h61;
      4'd10:   c = 8'h6C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sensor_hub_packet_receiver_unit.sv =====
// Top level of the sensor-hub packet receiver: header tracking, report capture,
// classification and the result register. Depends on shpr_pkg and shpr_advert.
//
// Usage:
//   Input stream (s_*): one packet byte per transaction, s_tuser[0] high on the
//   first header byte of a packet. Bytes outside a packet are dropped; a start
//   flag inside a packet abandons that packet without a result.
//   Output stream (m_*): one transaction per packet, issued for the byte that
//   completes the declared length (or the second byte of an empty packet).
//   The result is registered and appears the cycle after the completing byte.
//   Throughput: one byte per cycle while s_tready is high; s_tready stays high
//   while the result register is empty or is being emptied in the same cycle.
//   When the receiver stalls, the result holds and s_tready stays low until it
//   is taken, whether or not the next byte would complete a packet.
//   Reset clears the packet state, marks only channel 0 valid, clears all
//   channel roles and empties the result register.
`default_nettype none

module sensor_hub_packet_receiver_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output      logic         s_tready,
  input  wire logic [7:0]   s_tdata,   // [7:0] pkt_byte
  input  wire logic [0:0]   s_tuser,   // [0] pkt_start
  output      logic         m_tvalid,
  input  wire logic         m_tready,
  output      logic [119:0] m_tdata    // [3:0] result_kind, [11:4] pkt_channel,
                                       // [19:12] report_id, [27:20] seq_number,
                                       // [35:28] report_status, [51:36] quat_real,
                                       // [67:52] quat_i, [83:68] quat_j,
                                       // [99:84] quat_k, [115:100] accuracy_est
);
  import shpr_pkg::*;

  logic             receiving;
  logic [POS_W-1:0] byte_position, declared_length, len_n, p;
  logic [7:0]       current_channel, kind_byte, ch_n, kind_n, b;
  logic [7:0]       report_bytes [14];
  logic [7:0]       rb_n [14];
  logic             take, start, act, done, empty, ch_bad;
  shpr_result_t     res, res_next;
  shpr_adv_req_t    adv_req;
  shpr_roles_t      roles;

  assign b        = s_tdata;
  assign start    = s_tuser[0];
  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;
  assign act      = take && (start || receiving);

  always_comb begin
    p      = start ? '0 : byte_position;
    len_n  = declared_length;
    ch_n   = start ? 8'd0 : current_channel;
    kind_n = start ? 8'd0 : kind_byte;
    if (p == POS_W'(0)) len_n = {7'd0, b};
    else if (p == POS_W'(1)) len_n = {b[6:0], declared_length[7:0]};
    if (p == POS_W'(2)) ch_n = b;
    if (p == POS_W'(4)) kind_n = b;
    for (int i = 0; i < 14; i++)
      rb_n[i] = (p == POS_W'(9 + i)) ? b : report_bytes[i];

    done  = (p != '0) && (({1'b0, p} + 16'd1) >= {1'b0, len_n});
    empty = (p == POS_W'(1)) && (len_n == '0);
    ch_bad = (int'(ch_n) >= CHANNELS) || !roles.valid_map[ch_n[CH_W-1:0]];

    res_next             = '0;
    res_next.pkt_channel = ch_n;
    priority if (empty) begin
      res_next.result_kind = RES_EMPTY;
      res_next.pkt_channel = 8'd0;
    end else if (len_n < POS_W'(5)) begin
      res_next.result_kind = RES_SHORT;
    end else if (ch_bad) begin
      res_next.result_kind = RES_BAD_CH;
    end else if (ch_n == 8'd0) begin
      res_next.result_kind = (kind_n == KIND_ADVERT) ? RES_ADVERT :
                             (kind_n == KIND_ERRORS) ? RES_ERROR_LIST : RES_RESERVED;
    end else if (ch_n == roles.ctl_ch) begin
      res_next.result_kind = RES_CONTROL;
      res_next.report_id   = kind_n;
    end else if (ch_n != roles.inp_ch) begin
      res_next.result_kind = RES_UNASSIGNED;
    end else if (len_n < POS_W'(10)) begin
      res_next.result_kind = RES_SHORT;
    end else if (rb_n[0] != ROT_REPORT) begin
      res_next.result_kind = RES_SENSOR;
      res_next.report_id   = rb_n[0];
    end else if (len_n < POS_W'(23)) begin
      res_next.result_kind = RES_SHORT;
    end else begin
      res_next.result_kind   = RES_ROTATION;
      res_next.report_id     = rb_n[0];
      res_next.seq_number    = rb_n[1];
      res_next.report_status = rb_n[2];
      res_next.quat_i        = {rb_n[5], rb_n[4]};
      res_next.quat_j        = {rb_n[7], rb_n[6]};
      res_next.quat_k        = {rb_n[9], rb_n[8]};
      res_next.quat_real     = {rb_n[11], rb_n[10]};
      res_next.accuracy_est  = {rb_n[13], rb_n[12]};
    end
  end

  assign adv_req.restart = take && start;
  assign adv_req.take    = act && (p >= POS_W'(5)) && (ch_n == 8'd0) && (kind_n == 8'd0);
  assign adv_req.pos     = p;
  assign adv_req.len     = len_n;
  assign adv_req.data    = b;

  shpr_advert u_advert (
    .clk   (clk),
    .rst   (rst),
    .req   (adv_req),
    .roles (roles)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving       <= 1'b0;
      byte_position   <= '0;
      declared_length <= '0;
      current_channel <= 8'd0;
      kind_byte       <= 8'd0;
      m_tvalid        <= 1'b0;
      for (int i = 0; i < 14; i++) report_bytes[i] <= 8'd0;
    end else begin
      if (act) begin
        receiving       <= !done;
        byte_position   <= p + POS_W'(1);
        declared_length <= len_n;
        current_channel <= ch_n;
        kind_byte       <= kind_n;
        for (int i = 0; i < 14; i++) report_bytes[i] <= rb_n[i];
      end
      if (act && done) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act && done) res <= res_next;
  end

  assign m_tdata = res;

endmodule

`default_nettype wire

// ===== rtl/shpr_advert.sv =====
// Advertisement record walker: channel valid map and control/input roles.
// Depends on shpr_pkg.
`default_nettype none

module shpr_advert (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire shpr_pkg::shpr_adv_req_t req,
  output shpr_pkg::shpr_roles_t       roles
);
  import shpr_pkg::*;

  logic [POS_W-1:0]  record_next, record_next_next;
  logic [7:0]        record_tag, record_tag_next;
  logic [7:0]        record_len, record_len_next;
  logic [1:0]        name_flags, name_flags_next;
  logic [SLOT_W-1:0] advert_slot;
  logic [CHANNELS-1:0] valid_map;
  logic [1:0]        role_marks [CHANNELS];
  logic [7:0]        ctl_ch, inp_ch, ctl_scan, inp_scan;

  logic              slot_ok, at_tag, at_len, in_val, cut, commit;
  logic [POS_W+1:0]  rec_end;
  logic [POS_W-1:0]  idx, val_start;
  logic [7:0]        commit_len;
  logic [1:0]        mark;

  assign slot_ok = advert_slot < SLOT_W'(CHANNELS);

  always_comb begin
    at_tag    = req.pos == record_next;
    at_len    = {1'b0, req.pos} == ({1'b0, record_next} + 16'd1);
    in_val    = (req.pos < record_next) && (record_tag == TAG_NAME);
    rec_end   = {2'b00, req.pos} + 17'd1 + {9'd0, req.data};
    cut       = rec_end > {2'b00, req.len};
    val_start = record_next - {7'd0, record_len};
    idx       = req.pos - val_start;

    record_next_next = record_next;
    record_tag_next  = record_tag;
    record_len_next  = record_len;
    name_flags_next  = name_flags;
    commit           = 1'b0;
    commit_len       = record_len;

    priority if (at_tag) begin
      record_tag_next = req.data;
    end else if (at_len) begin
      record_len_next  = req.data;
      name_flags_next  = 2'b11;
      record_next_next = cut ? REC_NONE : rec_end[POS_W-1:0];
      record_tag_next  = cut ? 8'd0 : record_tag;
      commit_len       = req.data;
      commit           = (record_tag_next == TAG_NAME) && (req.data == 8'd0);
    end else if (in_val) begin
      if (idx < POS_W'(8) && req.data != ctl_char(idx[2:0])) name_flags_next[0] = 1'b0;
      if (idx < POS_W'(12) && req.data != inp_char(idx[3:0])) name_flags_next[1] = 1'b0;
      commit = (idx + POS_W'(1)) == {7'd0, record_len};
    end else begin
      commit = 1'b0;
    end

    mark[0] = name_flags_next[0] && (commit_len >= 8'd7);
    mark[1] = name_flags_next[1] && (commit_len >= 8'd11);
  end

  always_comb begin
    ctl_scan = 8'd0;
    inp_scan = 8'd0;
    for (int i = CHANNELS - 1; i >= 1; i--) begin
      if (role_marks[i][0]) ctl_scan = 8'(i);
      if (role_marks[i][1]) inp_scan = 8'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_next <= REC_FIRST;
      record_tag  <= 8'd0;
      record_len  <= 8'd0;
      name_flags  <= 2'b11;
      advert_slot <= '0;
      valid_map   <= CHANNELS'(1);
      for (int i = 0; i < CHANNELS; i++) role_marks[i] <= 2'b00;
      ctl_ch      <= 8'd0;
      inp_ch      <= 8'd0;
    end else begin
      ctl_ch <= ctl_scan;
      inp_ch <= inp_scan;
      if (req.restart) begin
        record_next <= REC_FIRST;
        record_tag  <= 8'd0;
        record_len  <= 8'd0;
        name_flags  <= 2'b11;
        advert_slot <= '0;
      end else if (req.take) begin
        record_next <= record_next_next;
        record_tag  <= record_tag_next;
        record_len  <= record_len_next;
        name_flags  <= name_flags_next;
        if (at_tag && req.data == TAG_CHANNEL && slot_ok)
          valid_map[advert_slot[CH_W-1:0]] <= 1'b1;
        if (commit && slot_ok) begin
          role_marks[advert_slot[CH_W-1:0]] <= mark;
          advert_slot <= advert_slot + SLOT_W'(1);
        end
      end
    end
  end

  assign roles.valid_map = valid_map;
  assign roles.ctl_ch    = ctl_ch;
  assign roles.inp_ch    = inp_ch;

endmodule

`default_nettype wire

// ===== dv/shpr_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the sensor-hub packet receiver: follows both streams, predicts each
// packet classification byte by byte and compares it with the output stream.
// Depends on shpr_pkg for the result layout, record tags and channel count.
module shpr_result_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [7:0]   s_tdata,
  input  wire logic [0:0]   s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [119:0] m_tdata,
  output int                mismatch_count,
  output int                results_pending
);
  import shpr_pkg::*;

  string        ctl_word = "control";
  string        inp_word = "inputNormal";

  bit           rx_active;
  int unsigned  pos, decl_len, rec_next, rec_tag, rec_len, slot;
  logic [7:0]   cur_ch, pkt_type;
  logic [1:0]   name_ok;
  bit           ch_valid [CHANNELS];
  logic [1:0]   ch_role [CHANNELS];
  logic [7:0]   rpt [14];
  shpr_result_t due_reports [$];

  function automatic logic [7:0] word_char(string w, int unsigned idx);
    return (idx < w.len()) ? w[idx] : 8'h00;
  endfunction

  function automatic void clear_state();
    rx_active = 1'b0;
    pos       = 0;
    decl_len  = 0;
    cur_ch    = '0;
    pkt_type  = '0;
    rec_next  = 32'(REC_FIRST);
    rec_tag   = 0;
    rec_len   = 0;
    name_ok   = 2'b11;
    slot      = 0;
    for (int i = 0; i < CHANNELS; i++) begin
      ch_valid[i] = (i == 0);
      ch_role[i]  = 2'b00;
    end
    for (int i = 0; i < 14; i++) rpt[i] = '0;
  endfunction

  function automatic void close_name();
    logic [1:0] m;
    if (slot < CHANNELS) begin
      m = 2'b00;
      if (name_ok[0] && rec_len >= ctl_word.len()) m[0] = 1'b1;
      if (name_ok[1] && rec_len >= inp_word.len()) m[1] = 1'b1;
      ch_role[slot] = m;
      slot++;
    end
  endfunction

  function automatic void walk_record(int unsigned p, int unsigned b);
    int unsigned stop, idx;
    if (p == rec_next) begin
      rec_tag = b;
      if (b == TAG_CHANNEL && slot < CHANNELS) ch_valid[slot] = 1'b1;
    end else if (p == rec_next + 1) begin
      stop    = p + 1 + b;
      rec_len = b;
      name_ok = 2'b11;
      if (stop > decl_len) begin
        rec_tag = 0;
        stop    = 32'(REC_NONE);
      end
      rec_next = stop;
      if (rec_tag == TAG_NAME && b == 0) close_name();
    end else if (p < rec_next && rec_tag == TAG_NAME) begin
      idx = p - (rec_next - rec_len);
      if (idx <= ctl_word.len() && b != word_char(ctl_word, idx)) name_ok[0] = 1'b0;
      if (idx <= inp_word.len() && b != word_char(inp_word, idx)) name_ok[1] = 1'b0;
      if (idx + 1 == rec_len) close_name();
    end
  endfunction

  function automatic shpr_result_t classify_packet();
    shpr_result_t r;
    int unsigned  ctl, inp;
    r = '0;
    ctl = 0;
    inp = 0;
    r.pkt_channel = cur_ch;
    if (decl_len < 5) begin
      r.result_kind = RES_SHORT;
      return r;
    end
    if (cur_ch >= CHANNELS || !ch_valid[cur_ch]) begin
      r.result_kind = RES_BAD_CH;
      return r;
    end
    if (cur_ch == 0) begin
      r.result_kind = (pkt_type == KIND_ADVERT) ? RES_ADVERT :
                      (pkt_type == KIND_ERRORS) ? RES_ERROR_LIST : RES_RESERVED;
      return r;
    end
    for (int i = CHANNELS - 1; i >= 1; i--) begin
      if (ch_role[i][0]) ctl = i;
      if (ch_role[i][1]) inp = i;
    end
    if (cur_ch == ctl) begin
      r.result_kind = RES_CONTROL;
      r.report_id   = pkt_type;
    end else if (cur_ch != inp) begin
      r.result_kind = RES_UNASSIGNED;
    end else if (decl_len < 10) begin
      r.result_kind = RES_SHORT;
    end else if (rpt[0] != ROT_REPORT) begin
      r.result_kind = RES_SENSOR;
      r.report_id   = rpt[0];
    end else if (decl_len < 23) begin
      r.result_kind = RES_SHORT;
    end else begin
      r.result_kind   = RES_ROTATION;
      r.report_id     = rpt[0];
      r.seq_number    = rpt[1];
      r.report_status = rpt[2];
      r.quat_real     = {rpt[11], rpt[10]};
      r.quat_i        = {rpt[5], rpt[4]};
      r.quat_j        = {rpt[7], rpt[6]};
      r.quat_k        = {rpt[9], rpt[8]};
      r.accuracy_est  = {rpt[13], rpt[12]};
    end
    return r;
  endfunction

  function automatic bit absorb_byte(input logic [7:0] b, input logic first,
                                     output shpr_result_t r);
    int unsigned p;
    r = '0;
    if (first) begin
      rx_active = 1'b1;
      pos       = 0;
      cur_ch    = '0;
      pkt_type  = '0;
      rec_next  = 32'(REC_FIRST);
      rec_tag   = 0;
      rec_len   = 0;
      name_ok   = 2'b11;
      slot      = 0;
    end
    if (!rx_active) return 1'b0;
    p = pos;
    if (p == 0) begin
      decl_len = 32'(b);
    end else if (p == 1) begin
      decl_len = 32'({b[6:0], decl_len[7:0]});
      if (decl_len == 0) begin
        rx_active = 1'b0;
        return 1'b1;
      end
    end else if (p == 2) begin
      cur_ch = b;
    end else if (p == 4) begin
      pkt_type = b;
    end
    if (p >= 9 && p <= 22) rpt[p - 9] = b;
    if (p >= 5 && cur_ch == 0 && pkt_type == KIND_ADVERT) walk_record(p, 32'(b));
    if (p >= 1 && p + 1 >= decl_len) begin
      r = classify_packet();
      rx_active = 1'b0;
      return 1'b1;
    end
    pos = (p + 1) & 32'h7FFF;
    return 1'b0;
  endfunction

  task automatic check_field(string label, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    shpr_result_t want, got;
    if (rst) begin
      clear_state();
      due_reports.delete();
      mismatch_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (absorb_byte(s_tdata, s_tuser[0], want)) due_reports.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = shpr_result_t'(m_tdata);
        if (due_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: result expected none actual %h", $time, m_tdata);
        end else begin
          want = due_reports.pop_front();
          check_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
          check_field("pkt_channel", 16'(want.pkt_channel), 16'(got.pkt_channel));
          check_field("report_id", 16'(want.report_id), 16'(got.report_id));
          check_field("seq_number", 16'(want.seq_number), 16'(got.seq_number));
          check_field("report_status", 16'(want.report_status), 16'(got.report_status));
          check_field("quat_real", want.quat_real, got.quat_real);
          check_field("quat_i", want.quat_i, got.quat_i);
          check_field("quat_j", want.quat_j, got.quat_j);
          check_field("quat_k", want.quat_k, got.quat_k);
          check_field("accuracy_est", want.accuracy_est, got.accuracy_est);
        end
      end
    end
    results_pending <= due_reports.size();
  end

endmodule

// ===== dv/tb_sensor_hub_packet_receiver_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the sensor-hub packet receiver: builds directed and random packet
// streams, drives them with random idling and gives the verdict. Depends on shpr_pkg,
// the receiver RTL and shpr_result_checker.
module tb_sensor_hub_packet_receiver_unit;
  import shpr_pkg::*;

  localparam int          STALL_LIMIT  = 2000;
  localparam int          RANDOM_BYTES = 800;
  localparam int unsigned KEEP_ALL     = 32'hFFFF;

  typedef struct packed {
    logic       first;
    logic [7:0] data;
  } stream_byte_t;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata  = '0;
  logic [0:0]   s_tuser  = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;
  int           mismatch_count;
  int           results_pending;
  int           sent_count   = 0;
  int           quiet_cycles = 0;
  stream_byte_t feed_q [$];
  byte unsigned body [$];
  logic [7:0]   ctl_hint = 8'd1;
  logic [7:0]   inp_hint = 8'd2;

  always #5 clk = ~clk;

  sensor_hub_packet_receiver_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  shpr_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  function automatic void send_packet(logic [7:0] ch, int unsigned decl, int unsigned keep,
                                      bit top);
    byte unsigned pkt [$];
    int unsigned  count;
    pkt.push_back(decl[7:0]);
    pkt.push_back({top, decl[14:8]});
    pkt.push_back(ch);
    pkt.push_back(8'($urandom));
    pkt = {pkt, body};
    count = (decl < 2) ? 2 : decl;
    while (pkt.size() < count) pkt.push_back(8'($urandom));
    for (int i = 0; i < count && i < keep; i++)
      feed_q.push_back('{first: (i == 0), data: pkt[i]});
    body.delete();
  endfunction

  function automatic void add_record(logic [7:0] tag, int unsigned n);
    body.push_back(tag);
    body.push_back(8'(n));
    repeat (n) body.push_back(8'($urandom));
  endfunction

  function automatic void add_name(string w, int unsigned variant);
    byte unsigned v [$];
    int unsigned  idx;
    for (int i = 0; i < w.len(); i++) v.push_back(w[i]);
    case (variant)
      1: begin
        v.push_back(8'h00);
        repeat ($urandom_range(3)) v.push_back(8'($urandom));
      end
      2: repeat ($urandom_range(1, 3)) void'(v.pop_back());
      3: begin
        idx = $urandom_range(w.len() - 1);
        v[idx] = v[idx] ^ 8'($urandom_range(1, 255));
      end
      4: v.push_back(8'($urandom_range(1, 255)));
      5: v.delete();
      6: begin
        v.delete();
        repeat ($urandom_range(1, 14)) v.push_back(8'($urandom));
      end
      default: ;
    endcase
    body.push_back(TAG_NAME);
    body.push_back(8'(v.size()));
    body = {body, v};
  endfunction

  function automatic void send_advert();
    int unsigned nslots, last, ctl_slot, inp_slot, full, decl, roll;
    nslots   = ($urandom_range(9) == 0) ? CHANNELS + $urandom_range(1, 2) : $urandom_range(3, 5);
    last     = (nslots > CHANNELS) ? CHANNELS - 1 : nslots - 1;
    ctl_slot = $urandom_range(1, last);
    inp_slot = $urandom_range(1, last);
    body.push_back(KIND_ADVERT);
    for (int s = 0; s < nslots; s++) begin
      if ($urandom_range(99) < 85) add_record(TAG_CHANNEL, $urandom_range(2));
      if ($urandom_range(99) < 20) add_record(8'($urandom), $urandom_range(3));
      if (s == ctl_slot) add_name("control", $urandom_range(1));
      else if (s == inp_slot) add_name("inputNormal", $urandom_range(1));
      else add_name($urandom_range(1) ? "control" : "inputNormal", $urandom_range(6));
    end
    full = body.size() + 4;
    roll = $urandom_range(9);
    decl = (roll == 0) ? $urandom_range(6, full - 1) :
           (roll == 1) ? full + $urandom_range(1, 6) : full;
    ctl_hint = 8'(ctl_slot);
    inp_hint = 8'(inp_slot);
    send_packet(8'h00, decl, KEEP_ALL, $urandom_range(3) == 0);
  endfunction

  function automatic logic [7:0] edge_byte();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void send_report(logic [7:0] ch);
    int unsigned roll, decl;
    repeat (5) body.push_back(8'($urandom));
    body.push_back(($urandom_range(4) != 0) ? ROT_REPORT : 8'($urandom));
    repeat (3) body.push_back(8'($urandom));
    repeat (10) body.push_back(edge_byte());
    roll = $urandom_range(99);
    decl = (roll < 75) ? 23 : (roll < 85) ? $urandom_range(24, 28) : $urandom_range(5, 22);
    send_packet(ch, decl, KEEP_ALL, $urandom_range(3) == 0);
  endfunction

  function automatic int unsigned gap_pct(bit receiver);
    case ((sent_count / 100) % 4)
      1:       return receiver ? 0 : 46;
      2:       return receiver ? 46 : 0;
      3:       return 10;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    stream_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) sent_count++;
      if (!s_tvalid || s_tready) begin
        if (feed_q.size() != 0 && $urandom_range(99) >= gap_pct(1'b0)) begin
          nxt = feed_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.data;
          s_tuser  <= nxt.first;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      quiet_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ? 0 : quiet_cycles + 1;
    end
    m_tready <= $urandom_range(99) >= gap_pct(1'b1);
  end

  initial begin
    int unsigned roll, pick, directed_len;
    // stray byte outside a packet, empty, short, bad channel, abandoned, error list, advert
    feed_q.push_back('{first: 1'b0, data: 8'hFF});
    send_packet(8'hFF, 0, KEEP_ALL, 1'b1);
    send_packet(8'h05, 3, KEEP_ALL, 1'b0);
    body.push_back(8'hFF);
    send_packet(8'hFF, 5, KEEP_ALL, 1'b0);
    send_packet(8'h01, 40, 3, 1'b0);
    body.push_back(KIND_ERRORS);
    send_packet(8'h00, 5, KEEP_ALL, 1'b0);
    body.push_back(KIND_ADVERT);
    send_packet(8'h00, 5, KEEP_ALL, 1'b0);
    directed_len = feed_q.size();

    send_advert();
    while (feed_q.size() < directed_len + RANDOM_BYTES) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        send_advert();
      end else if (roll < 62) begin
        pick = $urandom_range(99);
        send_report((pick < 65) ? inp_hint : (pick < 80) ? ctl_hint :
                    (pick < 92) ? 8'($urandom_range(1, CHANNELS - 1)) : 8'($urandom));
      end else if (roll < 72) begin
        body.push_back($urandom_range(1) ? KIND_ERRORS : 8'($urandom));
        send_packet(8'h00, $urandom_range(5, 8), KEEP_ALL, $urandom_range(3) == 0);
      end else if (roll < 84) begin
        send_packet(8'($urandom), $urandom_range(4), KEEP_ALL, 1'($urandom_range(1)));
      end else begin
        send_packet(8'($urandom), $urandom_range(20, 300), $urandom_range(1, 8),
                    1'($urandom_range(1)));
      end
      if ($urandom_range(19) == 0) feed_q.push_back('{first: 1'b0, data: 8'($urandom)});
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while ((feed_q.size() != 0 || s_tvalid || results_pending != 0) &&
           quiet_cycles < STALL_LIMIT)
      @(negedge clk);
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_sensor_hub_packet_receiver_unit: done, errors");
    end else begin
      repeat (10) @(posedge clk);
      if (mismatch_count == 0) begin
        $display("tb_sensor_hub_packet_receiver_unit: done, clean");
      end else begin
        $display("tb_sensor_hub_packet_receiver_unit: done, errors");
      end
    end
    $finish;
  end

endmodule
